// ----- rtl/mbps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES = 16;
  localparam int unsigned PAT_BITS   = 8 * MAX_PATTERN_BYTES;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned WIN_IDX_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LO     = 3'd0,
    REG_PATTERN_HI     = 3'd1,
    REG_MASK_LO        = 3'd2,
    REG_MASK_HI        = 3'd3,
    REG_PATTERN_LENGTH = 3'd4,
    REG_MARKER_OFFSET  = 3'd5
  } reg_idx_e;

  // window, entry 0 is the newest byte
  typedef logic [MAX_PATTERN_BYTES-1:0][7:0] win_t;

  typedef struct packed {
    logic [PAT_BITS-1:0] pattern;
    logic [PAT_BITS-1:0] mask;
    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    marker_offset;
  } cfg_t;

endpackage

// ----- rtl/mbps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps interfaces
// Valid/ready channels for input bytes, results and register writes.
// ----------------------------------------------------------------------------
interface mbps_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] byte_address;
  logic        first_of_region;

  modport source (output valid, data_byte, byte_address, first_of_region, input ready);
  modport sink (input valid, data_byte, byte_address, first_of_region, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        match_here;
  logic [15:0] occurrence_count;
  logic [31:0] found_address;
  logic        any_found;

  modport source (output valid, match_here, occurrence_count, found_address, any_found,
                  input ready);
  modport sink (input valid, match_here, occurrence_count, found_address, any_found,
                output ready);
endinterface

interface mbps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/masked_byte_pattern_scanner_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core
// Wildcard byte signature scanner, one byte per cycle while out_o is not held.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one stream byte per item with its address and a
//          start-of-region flag; every input item yields one result item.
//   out_o  carries match_here, the saturating occurrence count, the latest
//          found address (window start plus marker offset) and any_found.
//   cfg_i  writes registers by index: pattern lo/hi, mask lo/hi, pattern
//          length, marker offset. Write only while no item is in flight.
// Timing: an accepted item waits in the input register; the window shift,
//   the 16-byte masked compare and the count update are combinational
//   into the result register. One item per cycle is sustained while out_o
//   is not held. The compare width of 16 bytes sets the logic depth.
// Reset: window cleared, count and found address zero, pattern length 1.
// Stall: while out_o is held, the input register keeps one item and input
//   ready drops once both registers are full; nothing is lost.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_core
  import mbps_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  mbps_in_if.sink         in_i,
  mbps_out_if.source      out_o,
  mbps_cfg_if.sink        cfg_i
);

  cfg_t cfg;

  mbps_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid && cfg_i.ready),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  assign cfg_i.ready = 1'b1;

  // input register
  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic              s1_first_q;

  // result register
  logic               out_valid_q;
  logic               out_match_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [ADDR_W-1:0]  out_found_q;

  // scan state
  win_t               win_q, win_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic               rmatched_q, rmatched_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic [ADDR_W-1:0]  found_q, found_d;

  logic advance;
  logic in_take;
  logic win_hit;
  logic hit;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_take    = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= in_i.data_byte;
      s1_addr_q  <= in_i.byte_address;
      s1_first_q <= in_i.first_of_region;
    end
  end

  // a region start clears the window before the new byte goes in
  logic [LEN_W-1:0] cnt_base;
  always_comb begin
    win_d      = s1_first_q ? '0 : win_q;
    win_d      = {win_d[MAX_PATTERN_BYTES-2:0], s1_byte_q};
    cnt_base   = s1_first_q ? '0 : cnt_q;
    cnt_d      = (cnt_base < LEN_W'(MAX_PATTERN_BYTES)) ? cnt_base + LEN_W'(1) : cnt_base;
    rmatched_d = s1_first_q ? 1'b0 : rmatched_q;
  end

  mbps_match_unit u_match (
    .win_i (win_d),
    .cfg_i (cfg),
    .hit_o (win_hit)
  );

  always_comb begin
    hit     = !rmatched_d && (cnt_d >= cfg.len_eff) && win_hit;
    total_d = total_q;
    found_d = found_q;
    if (hit) begin
      if (total_q != {COUNT_W{1'b1}}) begin
        total_d = total_q + COUNT_W'(1);
      end
      found_d = s1_addr_q - ADDR_W'(cfg.len_eff) + ADDR_W'(1) + ADDR_W'(cfg.marker_offset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      cnt_q      <= '0;
      rmatched_q <= 1'b0;
      total_q    <= '0;
      found_q    <= '0;
    end else if (advance) begin
      win_q      <= win_d;
      cnt_q      <= cnt_d;
      rmatched_q <= rmatched_d || hit;
      total_q    <= total_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_match_q <= hit;
      out_count_q <= total_d;
      out_found_q <= found_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.match_here       = out_match_q;
  assign out_o.occurrence_count = out_count_q;
  assign out_o.found_address    = out_found_q;
  assign out_o.any_found        = (out_count_q != '0);

`ifndef NO_ASSERTIONS
  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("input register item dropped while stalled");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (total_q >= $past(total_q)))
    else $error("occurrence count decreased");

  a_match_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_match_q) |-> (out_count_q != '0))
    else $error("match reported with zero count");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LEN_W'(MAX_PATTERN_BYTES))
    else $error("region fill count out of range");

  a_one_match_per_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && rmatched_q && !s1_first_q) |-> !hit)
    else $error("second match counted in one region");
`endif

endmodule

// ----- rtl/mbps_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration register file; presents the clamped pattern length.
// ----------------------------------------------------------------------------
module mbps_cfg_regs
  import mbps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q, mask_lo_q, mask_hi_q;
  logic [LEN_W-1:0]      len_q, marker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      mask_lo_q <= '0;
      mask_hi_q <= '0;
      len_q     <= LEN_W'(1);
      marker_q  <= '0;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        REG_PATTERN_LO:     pat_lo_q  <= wr_data_i;
        REG_PATTERN_HI:     pat_hi_q  <= wr_data_i;
        REG_MASK_LO:        mask_lo_q <= wr_data_i;
        REG_MASK_HI:        mask_hi_q <= wr_data_i;
        REG_PATTERN_LENGTH: len_q     <= wr_data_i[LEN_W-1:0];
        REG_MARKER_OFFSET:  marker_q  <= wr_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.pattern       = {pat_hi_q, pat_lo_q};
    cfg_o.mask          = {mask_hi_q, mask_lo_q};
    cfg_o.marker_offset = marker_q;
    if (len_q == '0) begin
      cfg_o.len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN_BYTES)) begin
      cfg_o.len_eff = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      cfg_o.len_eff = len_q;
    end
  end

endmodule

// ----- rtl/mbps_match_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match_unit
// Masked compare of the newest len_eff window bytes against the pattern in parallel.
// ----------------------------------------------------------------------------
module mbps_match_unit
  import mbps_pkg::*;
(
  input  win_t  win_i,
  input  cfg_t  cfg_i,
  output logic  hit_o
);

  always_comb begin
    logic [LEN_W-1:0]     pos;
    logic [7:0]           pat_b, mask_b, win_b;
    hit_o = 1'b1;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      // pattern byte 0 lines up with the oldest byte of the window
      pos    = cfg_i.len_eff - LEN_W'(1) - LEN_W'(k);
      pat_b  = cfg_i.pattern[8*k +: 8];
      mask_b = cfg_i.mask[8*k +: 8];
      win_b  = win_i[pos[WIN_IDX_W-1:0]];
      if ((LEN_W'(k) < cfg_i.len_eff) && ((win_b & mask_b) != (pat_b & mask_b))) begin
        hit_o = 1'b0;
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked byte pattern scanner core. A table of
// directed bytes and register writes runs first, then random regions that
// mostly carry the masked pattern, then a short run with wildcard settings
// in which every region start matches. Every result item is compared field
// by field against a table entry or the byte-level predictor in this module.
// ----------------------------------------------------------------------------
module testbench
  import mbps_pkg::*;
();

  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 240;
  localparam int unsigned LIMIT_NS        = 4_000_000;

  typedef struct packed {
    logic        match_here;
    logic [15:0] occurrence_count;
    logic [31:0] found_address;
    logic        any_found;
  } scan_res_t;

  typedef enum {ROW_BYTE, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [63:0] value;
    logic [31:0] addr;
    logic        first;
    bit          typed;
    scan_res_t   res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mbps_in_if  in_bus ();
  mbps_out_if out_bus ();
  mbps_cfg_if cfg_bus ();

  masked_byte_pattern_scanner_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register shadows
  logic [PAT_BITS-1:0] pat_q;
  logic [PAT_BITS-1:0] msk_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    off_q;

  // scanner state
  logic [7:0]   win_q [MAX_PATTERN_BYTES];
  int unsigned  fill_q;
  bit           region_hit_q;
  logic [15:0]  match_total_q;
  logic [31:0]  last_found_q;

  scan_res_t   scan_results_q [$];
  stim_row_t   directed_rows [$];

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  bit          hold_off_req;

  int unsigned n_bytes_sent;
  int unsigned n_results_seen;
  int unsigned n_hits_seen;
  int unsigned n_reg_writes;
  int unsigned n_errors;

  function automatic int unsigned draw_wait(int unsigned pct);
    if ($urandom_range(99) < pct) return $urandom_range(1, 18);
    return 0;
  endfunction

  function automatic int unsigned eff_len();
    int unsigned n;
    n = len_q;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN_BYTES) n = MAX_PATTERN_BYTES;
    return n;
  endfunction

  // advance the scanner by one byte and return the result item it yields
  function automatic scan_res_t next_scan_result(logic [7:0] d, logic [31:0] a, logic f);
    scan_res_t   r;
    int unsigned n;
    bit          ok;
    logic [7:0]  p;
    logic [7:0]  m;
    n = eff_len();
    r.match_here = 1'b0;
    if (f) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) win_q[i] = 8'h00;
      fill_q = 0;
      region_hit_q = 1'b0;
    end
    for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = d;
    if (fill_q < MAX_PATTERN_BYTES) fill_q++;
    if (!region_hit_q && fill_q >= n) begin
      ok = 1'b1;
      // pattern byte 0 lines up with the oldest byte of the window
      for (int k = 0; k < n; k++) begin
        p = pat_q[8*k +: 8];
        m = msk_q[8*k +: 8];
        if ((win_q[n-1-k] & m) != (p & m)) ok = 1'b0;
      end
      if (ok) begin
        r.match_here = 1'b1;
        region_hit_q = 1'b1;
        if (match_total_q != 16'hFFFF) match_total_q++;
        last_found_q = a - (n - 1) + off_q;
      end
    end
    r.occurrence_count = match_total_q;
    r.found_address    = last_found_q;
    r.any_found        = (match_total_q != 0);
    return r;
  endfunction

  function automatic void add_byte_row(logic [7:0] d, logic [31:0] a, logic f,
                                       bit typed, scan_res_t res);
    stim_row_t row;
    row.kind  = ROW_BYTE;
    row.idx   = REG_PATTERN_LO;
    row.value = {56'h0, d};
    row.addr  = a;
    row.first = f;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg_row(reg_idx_e idx, logic [63:0] v);
    stim_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.value = v;
    row.addr  = '0;
    row.first = 1'b0;
    row.typed = 1'b0;
    row.res   = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic flag_field(string field, longint unsigned want_v, longint unsigned got_v);
    n_errors++;
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
  endtask

  // lower both request valids and wait until the block has handed back everything
  task automatic drain_results(int unsigned extra);
    in_bus.valid  <= 1'b0;
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (scan_results_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      REG_PATTERN_LO:     pat_q[63:0]   = v;
      REG_PATTERN_HI:     pat_q[127:64] = v;
      REG_MASK_LO:        msk_q[63:0]   = v;
      REG_MASK_HI:        msk_q[127:64] = v;
      REG_PATTERN_LENGTH: len_q         = v[LEN_W-1:0];
      REG_MARKER_OFFSET:  off_q         = v[LEN_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic send_byte(logic [7:0] d, logic [31:0] a, logic f, bit typed,
                           scan_res_t typed_res);
    int unsigned gap;
    scan_res_t   res;
    gap = draw_wait(in_idle_pct);
    cfg_bus.valid <= 1'b0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.data_byte       <= d;
    in_bus.byte_address    <= a;
    in_bus.first_of_region <= f;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    res = next_scan_result(d, a, f);
    scan_results_q.push_back(typed ? typed_res : res);
    n_bytes_sent++;
  endtask

  initial begin : watchdog
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : result_checker
    scan_res_t   want;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(out_idle_pct);
      end
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
      n_results_seen++;
      if (out_bus.match_here) n_hits_seen++;
      if (scan_results_q.size() == 0) begin
        n_errors++;
        $display("%0t: result item with none expected, got match %0b count %0d addr 0x%0h",
                 $time, out_bus.match_here, out_bus.occurrence_count, out_bus.found_address);
      end else begin
        want = scan_results_q.pop_front();
        if (out_bus.match_here !== want.match_here)
          flag_field("match_here", want.match_here, out_bus.match_here);
        if (out_bus.occurrence_count !== want.occurrence_count)
          flag_field("occurrence_count", want.occurrence_count, out_bus.occurrence_count);
        if (out_bus.found_address !== want.found_address)
          flag_field("found_address", want.found_address, out_bus.found_address);
        if (out_bus.any_found !== want.any_found)
          flag_field("any_found", want.any_found, out_bus.any_found);
      end
    end
  end

  initial begin : stimulus
    logic [7:0]          region_bytes [64];
    logic [PAT_BITS-1:0] new_pat;
    logic [PAT_BITS-1:0] new_msk;
    logic [63:0]         cfg_word;
    logic [31:0]         base;
    logic [31:0]         a;
    logic [7:0]          m;
    int unsigned         pick;
    int unsigned         rlen;
    int unsigned         n;
    int unsigned         pos;
    int unsigned         phase_bytes;
    int unsigned         in_pct_tbl [N_PHASES];
    int unsigned         out_pct_tbl [N_PHASES];
    bit                  head_first;

    in_pct_tbl  = '{10, 0, 60, 0, 30, 90, 0, 20};
    out_pct_tbl = '{0, 40, 10, 0, 90, 30, 60, 20};

    rst_ni                 = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.data_byte       = 8'h00;
    in_bus.byte_address    = 32'h0;
    in_bus.first_of_region = 1'b0;
    out_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_PATTERN_LO;
    cfg_bus.data           = 64'h0;
    hold_off_req           = 1'b0;
    in_idle_pct            = 20;
    out_idle_pct           = 20;
    n_bytes_sent   = 0;
    n_results_seen = 0;
    n_hits_seen    = 0;
    n_reg_writes   = 0;
    n_errors       = 0;

    pat_q = '0;
    msk_q = '0;
    len_q = 5'd1;
    off_q = 5'd0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) win_q[i] = 8'h00;
    fill_q        = 0;
    region_hit_q  = 1'b0;
    match_total_q = 16'h0;
    last_found_q  = 32'h0;

    // reset settings: one byte, all wildcard, so any byte matches at once;
    // bytes before the first region start belong to a region begun at reset
    add_byte_row(8'hFF, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 16'd1, 32'h0000_0000, 1'b1});
    add_byte_row(8'h00, 32'h0000_0001, 1'b0, 1'b1, '{1'b0, 16'd1, 32'h0000_0000, 1'b1});
    add_byte_row(8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 16'd2, 32'hFFFF_FFFF, 1'b1});
    // full 16 byte pattern with partly masked bytes, length and offset above range
    add_reg_row(REG_PATTERN_LO, 64'h0706_0504_0302_0100);
    add_reg_row(REG_PATTERN_HI, 64'h0F0E_0D0C_0B0A_0908);
    add_reg_row(REG_MASK_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    add_reg_row(REG_MASK_HI, 64'hFFFF_FFFF_FFFF_0F00);
    add_reg_row(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_reg_row(REG_MARKER_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int j = 0; j < 15; j++)
      add_byte_row((j == 8) ? 8'hA7 : (j == 9) ? 8'hF9 : 8'(j), 32'hFFFF_FFF4 + j,
                   (j == 0), 1'b0, '0);
    // the window ending on the last byte of the region counts; address wraps
    add_byte_row(8'h0F, 32'h0000_0003, 1'b0, 1'b1, '{1'b1, 16'd3, 32'h0000_0013, 1'b1});
    // zero length acts as one
    add_reg_row(REG_PATTERN_LENGTH, 64'h0);
    add_reg_row(REG_MARKER_OFFSET, 64'h0);
    add_reg_row(REG_MASK_LO, 64'h0000_0000_0000_00FF);
    add_byte_row(8'h01, 32'd100, 1'b1, 1'b1, '{1'b0, 16'd3, 32'h0000_0013, 1'b1});
    add_byte_row(8'h00, 32'd101, 1'b0, 1'b1, '{1'b1, 16'd4, 32'd101, 1'b1});
    add_byte_row(8'h00, 32'd200, 1'b0, 1'b1, '{1'b0, 16'd4, 32'd101, 1'b1});
    add_byte_row(8'h00, 32'd200, 1'b1, 1'b1, '{1'b1, 16'd5, 32'd200, 1'b1});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (i == 0 || directed_rows[i-1].kind == ROW_BYTE) drain_results(DRAIN_CYCLES);
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].value[7:0], directed_rows[i].addr, directed_rows[i].first,
                  directed_rows[i].typed, directed_rows[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results(DRAIN_CYCLES);
      new_pat = {$urandom, $urandom, $urandom, $urandom};
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        pick = $urandom_range(9);
        new_msk[8*k +: 8] = (pick < 6) ? 8'hFF : (pick < 8) ? 8'h00 : 8'($urandom);
      end
      write_reg(REG_PATTERN_LO, new_pat[63:0]);
      write_reg(REG_PATTERN_HI, new_pat[127:64]);
      write_reg(REG_MASK_LO, new_msk[63:0]);
      write_reg(REG_MASK_HI, new_msk[127:64]);
      // upper bits of the length and offset words carry noise
      cfg_word = {$urandom, $urandom};
      if (ph == 1) cfg_word[4:0] = 5'd16;
      else if (ph == 2) cfg_word[4:0] = 5'd1;
      else if ($urandom_range(5) == 0) cfg_word[4:0] = 5'($urandom_range(0, 31));
      else cfg_word[4:0] = 5'($urandom_range(1, 16));
      write_reg(REG_PATTERN_LENGTH, cfg_word);
      cfg_word = {$urandom, $urandom};
      write_reg(REG_MARKER_OFFSET, cfg_word);

      in_idle_pct  = in_pct_tbl[ph];
      out_idle_pct = out_pct_tbl[ph];
      // sink stops for a long stretch while the source keeps offering bytes
      if (ph == 3) hold_off_req = 1'b1;

      n = eff_len();
      phase_bytes = 0;
      while (phase_bytes < ITEMS_PER_PHASE) begin
        rlen = ($urandom_range(4) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
        base = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
        // filler leans on pattern bytes so near misses are common
        for (int j = 0; j < rlen; j++)
          region_bytes[j] = $urandom_range(1) ? 8'($urandom)
                                              : pat_q[8*$urandom_range(15) +: 8];
        if (rlen >= n && $urandom_range(9) < 7) begin
          pos = $urandom_range(0, rlen - n);
          for (int k = 0; k < n; k++) begin
            m = msk_q[8*k +: 8];
            region_bytes[pos+k] = (pat_q[8*k +: 8] & m) | (8'($urandom) & ~m);
          end
          if ($urandom_range(5) == 0) begin
            pick = pos + $urandom_range(0, n - 1);
            region_bytes[pick] = region_bytes[pick] ^ 8'(1 << $urandom_range(7));
          end
        end
        head_first = ($urandom_range(19) != 0);
        for (int j = 0; j < rlen; j++) begin
          if ($urandom_range(99) == 0 || (ph == 5 && phase_bytes == 0 && j == 0))
            drain_results(0);
          a = ($urandom_range(49) == 0) ? $urandom : base + j;
          send_byte(region_bytes[j], a, (j == 0) ? head_first : ($urandom_range(199) == 0),
                    1'b0, '0);
        end
        phase_bytes += rlen;
      end
    end

    // all wildcard, length one: every region-start byte matches, others do not
    drain_results(DRAIN_CYCLES);
    write_reg(REG_MASK_LO, 64'h0);
    write_reg(REG_MASK_HI, 64'h0);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_MARKER_OFFSET, 64'($urandom_range(0, 31)));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int j = 0; j < 24; j++)
      send_byte(8'($urandom), $urandom, j[0], 1'b0, '0);

    drain_results(2 * DRAIN_CYCLES);
    $display("%0d bytes scanned, %0d result items compared, %0d counted matches",
             n_bytes_sent, n_results_seen, n_hits_seen);
    $display("%0d register writes over %0d random settings, final count 0x%0h",
             n_reg_writes, N_PHASES, match_total_q);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- masked_byte_pattern_scanner_core.f -----
rtl/mbps_pkg.sv
rtl/mbps_if.sv
rtl/mbps_cfg_regs.sv
rtl/mbps_match_unit.sv
rtl/masked_byte_pattern_scanner_core.sv
tb/testbench.sv
